### rtl/rvtu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvtu_pkg - shared types and constants of the trap unit
// Codes, mstatus bit positions, interrupt priority order and the payload
// structs used by the channels and between the trap unit modules.
// ----------------------------------------------------------------------------
package rvtu_pkg;

   localparam int XLEN         = 32;
   localparam int IRQ_W        = 14;
   localparam int EXC_DELEG_W  = 16;
   localparam int CAUSE_W      = 5;
   localparam int IRQ_CODE_W   = 4;
   localparam int CSR_IDX_W    = 3;

   // Action codes presented with each item
   localparam logic [1:0] ActNone = 2'd0;
   localparam logic [1:0] ActExc  = 2'd1;
   localparam logic [1:0] ActMret = 2'd2;
   localparam logic [1:0] ActSret = 2'd3;

   // Event codes returned with each result
   localparam logic [2:0] EvtNone   = 3'd0;
   localparam logic [2:0] EvtTrapM  = 3'd1;
   localparam logic [2:0] EvtTrapS  = 3'd2;
   localparam logic [2:0] EvtReturn = 3'd3;
   localparam logic [2:0] EvtWake   = 3'd4;
   localparam logic [2:0] EvtError  = 3'd5;

   // Privilege levels
   localparam logic [1:0] PrivUser    = 2'd0;
   localparam logic [1:0] PrivSuper   = 2'd1;
   localparam logic [1:0] PrivInvalid = 2'd2;
   localparam logic [1:0] PrivMachine = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CsrIrqEnable = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CsrIrqDeleg  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CsrExcDeleg  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CsrMtvec     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CsrStvec     = 3'd4;

   // mstatus bit positions
   localparam int StSie    = 1;
   localparam int StMie    = 3;
   localparam int StSpie   = 5;
   localparam int StMpie   = 7;
   localparam int StSpp    = 8;
   localparam int StMppLo  = 11;
   localparam int StMppHi  = 12;
   localparam int StMprv   = 17;

   localparam logic [1:0] VecModeVectored = 2'd1;

   // Environment call causes
   localparam logic [CAUSE_W-1:0] EcallCauseBase    = 5'd8;
   localparam logic [CAUSE_W-1:0] EcallCauseMachine = 5'd11;

   // Interrupt priority order, highest first
   localparam int MOrderN = 7;
   localparam int SOrderN = 4;
   localparam logic [IRQ_CODE_W-1:0] MOrder [MOrderN] =
      '{4'd11, 4'd3, 4'd7, 4'd9, 4'd1, 4'd5, 4'd13};
   localparam logic [IRQ_CODE_W-1:0] SOrder [SOrderN] =
      '{4'd9, 4'd1, 4'd5, 4'd13};

   typedef struct packed {
      logic [1:0]         action;
      logic               from_fetch;
      logic               is_ecall;
      logic [CAUSE_W-1:0] cause;
      logic [1:0]         priv;
      logic [XLEN-1:0]    exception_pc;
      logic [XLEN-1:0]    trap_value;
      logic               defer;
      logic               waiting;
      logic [XLEN-1:0]    resume_pc;
      logic [XLEN-1:0]    interrupt_pc;
      logic [IRQ_W-1:0]   pending_lines;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]      event_res;
      logic [XLEN-1:0] redirect_pc;
      logic [1:0]      new_priv;
      logic [XLEN-1:0] status_out;
      logic [XLEN-1:0] cause_out;
      logic [XLEN-1:0] saved_epc;
      logic [XLEN-1:0] saved_tval;
   } rsp_payload_type;

   // Architectural state and configuration seen by the trap logic
   typedef struct packed {
      logic [XLEN-1:0]        status;
      logic [XLEN-1:0]        mepc;
      logic [XLEN-1:0]        sepc;
      logic [IRQ_W-1:0]       mie;
      logic [IRQ_W-1:0]       mideleg;
      logic [EXC_DELEG_W-1:0] medeleg;
      logic [XLEN-1:0]        mtvec;
      logic [XLEN-1:0]        stvec;
   } trap_state_type;

   // State writes caused by one item
   typedef struct packed {
      logic [XLEN-1:0] status_next;
      logic            mepc_we;
      logic            sepc_we;
      logic [XLEN-1:0] epc_value;
   } state_update_type;

endpackage

### rtl/rvtu_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvtu_req_if - input channel of the trap unit
// Valid/ready handshake carrying one core cycle's trap request per item.
// ----------------------------------------------------------------------------
interface rvtu_req_if
   import rvtu_pkg::*;
   ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/rvtu_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvtu_rsp_if - result channel of the trap unit
// Valid/ready handshake carrying one trap decision per item.
// ----------------------------------------------------------------------------
interface rvtu_rsp_if
   import rvtu_pkg::*;
   ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/riscv_trap_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riscv_trap_unit - RISC-V trap and delegation unit
// Decides per core cycle whether to trap, return or wake, and keeps mstatus
// and the exception return addresses.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one item per core cycle: the action (exception, mret,
//   sret or none), its pc and fault value, and the pending interrupt lines.
//   rsp_if returns one item for each request: the event, the redirect pc,
//   the new privilege and the mstatus, cause, epc and tval values written.
//   csr_* writes mie, mideleg, medeleg, mtvec and stvec; write them only
//   while no item is in flight.
//   Path: an accepted request goes into the request register, where the
//   decision logic and the state update run, then into the result register.
//   Throughput is one item per cycle while the receiver does not stall.
//   The state update happens as an item leaves the request register, so the
//   next item sees the state of the previous one with no bubble.
//   When the receiver stalls, the result register holds and the request
//   register holds one further item; req_if.ready falls once both are full.
//   Synchronous reset empties both registers and clears mstatus, the epc
//   registers and all configuration registers.
// ----------------------------------------------------------------------------
module riscv_trap_unit
   import rvtu_pkg::*;
   (
   input  logic                 clock,
   input  logic                 reset,
   rvtu_req_if.sink             req_if,
   rvtu_rsp_if.source           rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [XLEN-1:0]      csr_wdata
   );

   // Configuration registers
   logic [IRQ_W-1:0]       mie_ff;
   logic [IRQ_W-1:0]       mideleg_ff;
   logic [EXC_DELEG_W-1:0] medeleg_ff;
   logic [XLEN-1:0]        mtvec_ff;
   logic [XLEN-1:0]        stvec_ff;

   // Architectural state
   logic [XLEN-1:0]        status_ff;
   logic [XLEN-1:0]        mepc_ff;
   logic [XLEN-1:0]        sepc_ff;

   // Pipeline registers
   logic                   s1_valid_ff;
   req_payload_type        s1_data_ff;
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_data_ff;

   logic                   rsp_advance;
   logic                   s1_advance;
   logic                   req_ready;
   trap_state_type         state;
   rsp_payload_type        calc_result;
   state_update_type       calc_upd;

   // Handshake
   assign rsp_advance = !rsp_valid_ff || rsp_if.ready;
   assign s1_advance  = s1_valid_ff && rsp_advance;
   assign req_ready   = !s1_valid_ff || rsp_advance;

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   assign state.status  = status_ff;
   assign state.mepc    = mepc_ff;
   assign state.sepc    = sepc_ff;
   assign state.mie     = mie_ff;
   assign state.mideleg = mideleg_ff;
   assign state.medeleg = medeleg_ff;
   assign state.mtvec   = mtvec_ff;
   assign state.stvec   = stvec_ff;

   rvtu_trap_calc u_trap_calc (
      .item   (s1_data_ff),
      .state  (state),
      .result (calc_result),
      .upd    (calc_upd)
   );

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mie_ff     <= '0;
         mideleg_ff <= '0;
         medeleg_ff <= '0;
         mtvec_ff   <= '0;
         stvec_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrIrqEnable: mie_ff     <= csr_wdata[IRQ_W-1:0];
            CsrIrqDeleg:  mideleg_ff <= csr_wdata[IRQ_W-1:0];
            CsrExcDeleg:  medeleg_ff <= csr_wdata[EXC_DELEG_W-1:0];
            CsrMtvec:     mtvec_ff   <= csr_wdata;
            CsrStvec:     stvec_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Commit state as an item leaves the request register
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
         mepc_ff   <= '0;
         sepc_ff   <= '0;
      end else if (s1_advance) begin
         status_ff <= calc_upd.status_next;
         if (calc_upd.mepc_we) begin
            mepc_ff <= calc_upd.epc_value;
         end
         if (calc_upd.sepc_we) begin
            sepc_ff <= calc_upd.epc_value;
         end
      end
   end

   // Request register: take a new item whenever it is free or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_if.valid) begin
         s1_data_ff <= req_if.data;
      end
   end

   // Result register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= calc_result;
      end
   end

`ifndef SYNTHESIS
   // An item leaving the request register always lands in the result register
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("item lost between request and result register");

   // A blocked request register keeps its item
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_advance) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("request register changed while blocked");

   // State changes only when an item is committed
   a_state_commit: assert property (@(posedge clock) disable iff (reset)
      !s1_advance |=> ($stable(status_ff) && $stable(mepc_ff) && $stable(sepc_ff)))
      else $error("trap state changed without a committed item");

   // A trap to M always clears MIE
   a_trap_m_mie: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.event_res == EvtTrapM))
         |-> !rsp_data_ff.status_out[StMie])
      else $error("trap to M left MIE set");

   // Only traps report cause, epc and tval
   a_no_trap_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.event_res != EvtTrapM)
                    && (rsp_data_ff.event_res != EvtTrapS))
         |-> ((rsp_data_ff.cause_out == '0) && (rsp_data_ff.saved_epc == '0)
              && (rsp_data_ff.saved_tval == '0)))
      else $error("trap fields set on a non-trap event");
`endif

endmodule

### rtl/rvtu_irq_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvtu_irq_pick - interrupt selection
// Splits enabled pending interrupts into machine and supervisor sets and
// picks the highest priority one that the current privilege may take.
// ----------------------------------------------------------------------------
module rvtu_irq_pick
   import rvtu_pkg::*;
   (
   input  logic [1:0]            priv,
   input  logic                  status_mie,
   input  logic                  status_sie,
   input  logic [IRQ_W-1:0]      pend,
   input  logic [IRQ_W-1:0]      mideleg,
   output logic                  found,
   output logic [IRQ_CODE_W-1:0] code
   );

   logic             m_ie;
   logic             s_ie;
   logic [IRQ_W-1:0] m_en;
   logic [IRQ_W-1:0] s_en;
   logic             m_hit;
   logic             s_hit;
   logic [IRQ_CODE_W-1:0] m_code;
   logic [IRQ_CODE_W-1:0] s_code;

   // Global enables by privilege
   assign m_ie = (priv == PrivMachine) ? status_mie : 1'b1;
   assign s_ie = (priv == PrivSuper) ? status_sie : (priv == PrivUser);
   assign m_en = pend & ~mideleg;
   assign s_en = pend & mideleg;

   // Scan lowest priority first so the highest hit wins
   always_comb begin
      m_hit  = 1'b0;
      m_code = '0;
      for (int i = MOrderN - 1; i >= 0; i--) begin
         if (m_en[MOrder[i]]) begin
            m_hit  = 1'b1;
            m_code = MOrder[i];
         end
      end
      s_hit  = 1'b0;
      s_code = '0;
      for (int i = SOrderN - 1; i >= 0; i--) begin
         if (s_en[SOrder[i]]) begin
            s_hit  = 1'b1;
            s_code = SOrder[i];
         end
      end
   end

   // Machine interrupts before supervisor ones
   always_comb begin
      priority if (m_ie && m_hit) begin
         found = 1'b1;
         code  = m_code;
      end else if (s_ie && s_hit) begin
         found = 1'b1;
         code  = s_code;
      end else begin
         found = 1'b0;
         code  = '0;
      end
   end

endmodule

### rtl/rvtu_trap_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvtu_trap_calc - trap decision logic
// From one registered request and the current state, decides the event,
// builds the target and the new mstatus, and the state writes to make.
// ----------------------------------------------------------------------------
module rvtu_trap_calc
   import rvtu_pkg::*;
   (
   input  req_payload_type  item,
   input  trap_state_type   state,
   output rsp_payload_type  result,
   output state_update_type upd
   );

   logic [IRQ_W-1:0]       pend;
   logic                   irq_found;
   logic [IRQ_CODE_W-1:0]  irq_code;

   logic                   trap_intr;
   logic [CAUSE_W-1:0]     trap_code;
   logic [XLEN-1:0]        trap_epc;
   logic [XLEN-1:0]        trap_tval;
   logic [CAUSE_W-1:0]     exc_code;
   logic [EXC_DELEG_W-1:0] deleg;
   logic                   to_s;
   logic [XLEN-1:0]        trap_vec;
   logic [XLEN-1:0]        vec_base;
   logic [XLEN-1:0]        trap_target;
   logic [XLEN-1:0]        trap_status;
   logic [XLEN-1:0]        cause_word;

   logic [1:0]             mret_prev;
   logic [XLEN-1:0]        mret_status;
   logic [1:0]             sret_prev;
   logic [XLEN-1:0]        sret_status;

   assign pend = item.pending_lines & state.mie;

   rvtu_irq_pick u_irq_pick (
      .priv       (item.priv),
      .status_mie (state.status[StMie]),
      .status_sie (state.status[StSie]),
      .pend       (pend),
      .mideleg    (state.mideleg),
      .found      (irq_found),
      .code       (irq_code)
   );

   // Remap environment calls by privilege
   always_comb begin
      if (!item.is_ecall) begin
         exc_code = item.cause;
      end else if (item.priv == PrivMachine) begin
         exc_code = EcallCauseMachine;
      end else begin
         exc_code = EcallCauseBase + CAUSE_W'(item.priv);
      end
   end

   // Trap source: an exception when one is presented, else the interrupt
   assign trap_intr = (item.action != ActExc);
   assign trap_code = trap_intr ? CAUSE_W'(irq_code) : exc_code;
   assign trap_epc  = trap_intr ? (item.waiting ? item.resume_pc : item.interrupt_pc)
                                : item.exception_pc;
   assign trap_tval = trap_intr ? '0 : item.trap_value;

   // Delegate to S when below M and the cause bit is set
   assign deleg = trap_intr ? EXC_DELEG_W'(state.mideleg) : state.medeleg;
   assign to_s  = (item.priv != PrivMachine) && !trap_code[CAUSE_W-1]
                  && deleg[trap_code[CAUSE_W-2:0]];

   assign cause_word = {trap_intr, {(XLEN-CAUSE_W-1){1'b0}}, trap_code};

   // Direct or vectored target
   assign trap_vec = to_s ? state.stvec : state.mtvec;
   assign vec_base = {trap_vec[XLEN-1:2], 2'b00};
   always_comb begin
      if (trap_intr && (trap_vec[1:0] == VecModeVectored)) begin
         trap_target = vec_base + {{(XLEN-CAUSE_W-2){1'b0}}, trap_code, 2'b00};
      end else begin
         trap_target = vec_base;
      end
   end

   // Stack the interrupt enable and previous privilege
   always_comb begin
      trap_status = state.status;
      if (to_s) begin
         trap_status[StSpie] = state.status[StSie];
         trap_status[StSpp]  = (item.priv == PrivSuper);
         trap_status[StSie]  = 1'b0;
      end else begin
         trap_status[StMpie]           = state.status[StMie];
         trap_status[StMppHi:StMppLo] = item.priv;
         trap_status[StMie]            = 1'b0;
      end
   end

   // Unstack on mret
   assign mret_prev = state.status[StMppHi:StMppLo];
   always_comb begin
      mret_status                   = state.status;
      mret_status[StMie]            = state.status[StMpie];
      mret_status[StMpie]           = 1'b1;
      mret_status[StMppHi:StMppLo] = PrivUser;
      if (mret_prev != PrivMachine) begin
         mret_status[StMprv] = 1'b0;
      end
   end

   // Unstack on sret
   assign sret_prev = {1'b0, state.status[StSpp]};
   always_comb begin
      sret_status         = state.status;
      sret_status[StSie]  = state.status[StSpie];
      sret_status[StSpie] = 1'b1;
      sret_status[StSpp]  = 1'b0;
      sret_status[StMprv] = 1'b0;
   end

   // Select the event
   always_comb begin
      logic take;
      take               = 1'b0;
      result.event_res   = EvtNone;
      result.redirect_pc = '0;
      result.new_priv    = item.priv;
      result.status_out  = state.status;
      result.cause_out   = '0;
      result.saved_epc   = '0;
      result.saved_tval  = '0;
      upd.status_next    = state.status;
      upd.mepc_we        = 1'b0;
      upd.sepc_we        = 1'b0;
      upd.epc_value      = {trap_epc[XLEN-1:2], 2'b00};

      unique case (item.action)
         ActMret: begin
            result.event_res   = EvtReturn;
            result.redirect_pc = {state.mepc[XLEN-1:2], 2'b00};
            result.new_priv    = mret_prev;
            result.status_out  = mret_status;
            upd.status_next    = mret_status;
         end
         ActSret: begin
            result.event_res   = EvtReturn;
            result.redirect_pc = {state.sepc[XLEN-1:2], 2'b00};
            result.new_priv    = sret_prev;
            result.status_out  = sret_status;
            upd.status_next    = sret_status;
         end
         ActExc: begin
            priority if (item.from_fetch && item.defer) begin
               // drop a deferred fetch exception
            end else if (item.priv == PrivInvalid) begin
               result.event_res = EvtError;
            end else begin
               take = 1'b1;
            end
         end
         default: begin
            priority if (item.defer || (pend == '0)) begin
               // nothing to do this cycle
            end else if (item.priv == PrivInvalid) begin
               result.event_res = EvtError;
            end else if (irq_found) begin
               take = 1'b1;
            end else if (item.waiting) begin
               result.event_res   = EvtWake;
               result.redirect_pc = item.resume_pc;
            end
         end
      endcase

      if (take) begin
         result.event_res   = to_s ? EvtTrapS : EvtTrapM;
         result.redirect_pc = trap_target;
         result.new_priv    = to_s ? PrivSuper : PrivMachine;
         result.status_out  = trap_status;
         result.cause_out   = cause_word;
         result.saved_epc   = {trap_epc[XLEN-1:2], 2'b00};
         result.saved_tval  = trap_tval;
         upd.status_next    = trap_status;
         upd.mepc_we        = !to_s;
         upd.sepc_we        = to_s;
      end
   end

endmodule
